// File: rtl/tcf_pkg.sv
// Shared constants, codes and types for the two-class oldest-first FIFO.
`timescale 1ns / 1ps

package tcf_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int TAG_BITS    = 16;
  localparam int STAMP_BITS  = 16;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_ENQ     = 2'd0,
    OP_DEQ_OLD = 2'd1,
    OP_DEQ_DOG = 2'd2,
    OP_DEQ_CAT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_REFUSED = 2'd3
  } status_t;

  localparam logic [1:0] CLS_DOG = 2'd0;
  localparam logic [1:0] CLS_CAT = 2'd1;

  typedef struct packed {
    logic [TAG_BITS-1:0]   tag;
    logic [STAMP_BITS-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

// File: rtl/tcf_queue.sv
// One bounded ring FIFO of stamped entries with the head entry always visible.
`timescale 1ns / 1ps

module tcf_queue
  import tcf_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  logic   pop,
  input  entry_t push_entry,
  output entry_t head_entry,
  output q_stat_t stat
);

  entry_t              entries_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] head_r;
  logic [PTR_BITS-1:0] head_nxt;
  logic [CNT_BITS-1:0] count_r;
  logic [CNT_BITS-1:0] count_nxt;
  logic [CNT_BITS:0]   tail_sum;
  logic [PTR_BITS-1:0] tail;

  // tail = (head + count) mod depth; the sum stays below twice the depth
  always_comb begin
    tail_sum = (CNT_BITS + 1)'(head_r) + (CNT_BITS + 1)'(count_r);
    if (tail_sum >= (CNT_BITS + 1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (CNT_BITS + 1)'(QUEUE_DEPTH);
    end
    tail = tail_sum[PTR_BITS-1:0];
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (push) begin
      count_nxt = count_r + 1'b1;
    end else if (pop) begin
      count_nxt = count_r - 1'b1;
      if (head_r == PTR_BITS'(QUEUE_DEPTH - 1)) begin
        head_nxt = '0;
      end else begin
        head_nxt = head_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[tail] <= push_entry;
    end
  end

  assign head_entry = entries_r[head_r];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_BITS'(QUEUE_DEPTH));

endmodule

// File: rtl/two_class_fifo_oldest_first.sv
// Top level: two class queues sharing an arrival stamp, oldest-first dequeue.
// A command is captured in the input register and then raises out_valid from the result
// register for one cycle, along with its result. Throughput: one command per
// cycle, busy stays low; each command is decoded from the input register against
// the queue heads and counts, and the result register and queue state update together.
// Reset (synchronous, rst_n low): both queues empty, stamp counter zero, no strobe.
`timescale 1ns / 1ps

module two_class_fifo_oldest_first
  import tcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [1:0]  in_item_class,
  input  logic [15:0] in_item_tag,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_tag,
  output logic        out_class
);

  logic                  in_valid_r;
  op_t                   op_r;
  logic [1:0]            cls_r;
  logic [TAG_BITS-1:0]   tag_r;

  logic [STAMP_BITS-1:0] next_stamp_r;
  logic [STAMP_BITS-1:0] next_stamp_nxt;

  logic                  out_valid_r;
  status_t               status_r;
  status_t               status_nxt;
  logic [15:0]           otag_r;
  logic [15:0]           otag_nxt;
  logic                  ocls_r;
  logic                  ocls_nxt;

  logic                  dog_push;
  logic                  cat_push;
  logic                  dog_pop;
  logic                  cat_pop;
  entry_t                new_entry;
  entry_t                dog_head;
  entry_t                cat_head;
  q_stat_t               dog_stat;
  q_stat_t               cat_stat;
  logic [STAMP_BITS-1:0] stamp_diff;

  assign busy = 1'b0;

  // register the command for decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r  <= op_t'(in_op);
      cls_r <= in_item_class;
      tag_r <= TAG_BITS'(in_item_tag);
    end
  end

  assign new_entry.tag   = tag_r;
  assign new_entry.stamp = next_stamp_r;
  assign stamp_diff      = dog_head.stamp - cat_head.stamp;

  always_comb begin
    dog_push       = 1'b0;
    cat_push       = 1'b0;
    dog_pop        = 1'b0;
    cat_pop        = 1'b0;
    status_nxt     = ST_OK;
    otag_nxt       = '0;
    ocls_nxt       = 1'b0;
    next_stamp_nxt = next_stamp_r;
    if (in_valid_r) begin
      case (op_r)
        OP_ENQ: begin
          if (cls_r == CLS_DOG) begin
            if (dog_stat.full) begin
              status_nxt = ST_FULL;
            end else begin
              dog_push = 1'b1;
            end
          end else if (cls_r == CLS_CAT) begin
            if (cat_stat.full) begin
              status_nxt = ST_FULL;
            end else begin
              cat_push = 1'b1;
            end
          end else begin
            status_nxt = ST_REFUSED;
          end
        end
        OP_DEQ_DOG: dog_pop = !dog_stat.empty;
        OP_DEQ_CAT: cat_pop = !cat_stat.empty;
        default: begin
          // equal stamps go to the cat queue; dog only when strictly older
          if (!dog_stat.empty && !cat_stat.empty) begin
            dog_pop = stamp_diff[STAMP_BITS-1];
            cat_pop = !stamp_diff[STAMP_BITS-1];
          end else begin
            dog_pop = !dog_stat.empty;
            cat_pop = !cat_stat.empty;
          end
        end
      endcase

      if (dog_push || cat_push) begin
        next_stamp_nxt = next_stamp_r + 1'b1;
      end
      if (dog_pop) begin
        otag_nxt = 16'(dog_head.tag);
      end else if (cat_pop) begin
        otag_nxt = 16'(cat_head.tag);
        ocls_nxt = 1'b1;
      end else if (op_r != OP_ENQ) begin
        status_nxt = ST_EMPTY;
      end
    end
  end

  tcf_queue u_dog_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (dog_push),
    .pop        (dog_pop),
    .push_entry (new_entry),
    .head_entry (dog_head),
    .stat       (dog_stat)
  );

  tcf_queue u_cat_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cat_push),
    .pop        (cat_pop),
    .push_entry (new_entry),
    .head_entry (cat_head),
    .stat       (cat_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      next_stamp_r <= '0;
    end else begin
      out_valid_r  <= in_valid_r;
      next_stamp_r <= next_stamp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    otag_r   <= otag_nxt;
    ocls_r   <= ocls_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_tag    = otag_r;
  assign out_class  = ocls_r;

endmodule

// File: test/tcf_checker.sv
// Scoreboard for the two-class FIFO: tracks both rings and checks every result strobe.
`timescale 1ns / 1ps

module tcf_checker
  import tcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_op,
  input  logic [1:0]  in_item_class,
  input  logic [15:0] in_item_tag,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [15:0] out_tag,
  input  logic        out_class,
  output int          fail_count,
  output int          outstanding,
  output int          n_cmds,
  output int          n_full,
  output int          n_empty,
  output int          n_refused,
  output int          stamp_wraps
);

  typedef struct packed {
    status_t             status;
    logic [TAG_BITS-1:0] tag;
    logic                cls;
  } shelter_result_t;

  // Index 0 is the dog ring, index 1 the cat ring.
  entry_t                ring_q  [2][QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   head_q  [2];
  logic [CNT_BITS-1:0]   count_q [2];
  logic [STAMP_BITS-1:0] stamp_ctr;
  shelter_result_t       results_due [$];

  function automatic shelter_result_t serve_command(op_t op, logic [1:0] cls,
                                                    logic [15:0] tag);
    shelter_result_t       r;
    int                    slot;
    int                    pick;
    logic [STAMP_BITS-1:0] age_gap;
    r.status = ST_OK;
    r.tag    = '0;
    r.cls    = 1'b0;
    pick     = -1;
    if (op == OP_ENQ) begin
      if (cls != CLS_DOG && cls != CLS_CAT) begin
        r.status = ST_REFUSED;
      end else if (count_q[cls[0]] == CNT_BITS'(QUEUE_DEPTH)) begin
        r.status = ST_FULL;
      end else begin
        slot = (int'(head_q[cls[0]]) + int'(count_q[cls[0]])) % QUEUE_DEPTH;
        ring_q[cls[0]][slot].tag   = tag;
        ring_q[cls[0]][slot].stamp = stamp_ctr;
        stamp_ctr = stamp_ctr + 1'b1;
        if (stamp_ctr == '0) stamp_wraps++;
        count_q[cls[0]] = count_q[cls[0]] + 1'b1;
      end
    end else begin
      case (op)
        OP_DEQ_DOG: pick = (count_q[0] != 0) ? 0 : -1;
        OP_DEQ_CAT: pick = (count_q[1] != 0) ? 1 : -1;
        default: begin
          if (count_q[0] != 0 && count_q[1] != 0) begin
            // Dog goes first only when strictly older, modulo the stamp width
            age_gap = ring_q[0][head_q[0]].stamp - ring_q[1][head_q[1]].stamp;
            pick = age_gap[STAMP_BITS-1] ? 0 : 1;
          end else if (count_q[0] != 0) begin
            pick = 0;
          end else if (count_q[1] != 0) begin
            pick = 1;
          end
        end
      endcase
      if (pick < 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.tag = ring_q[pick][head_q[pick]].tag;
        r.cls = pick[0];
        head_q[pick]  = PTR_BITS'((int'(head_q[pick]) + 1) % QUEUE_DEPTH);
        count_q[pick] = count_q[pick] - 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    shelter_result_t due;
    shelter_result_t fresh;
    if (!rst_n) begin
      head_q      = '{default: '0};
      count_q     = '{default: '0};
      stamp_ctr   = '0;
      results_due.delete();
      fail_count  = 0;
      n_cmds      = 0;
      n_full      = 0;
      n_empty     = 0;
      n_refused   = 0;
      stamp_wraps = 0;
    end else begin
      // Check the strobe before taking this edge's command
      if (out_valid) begin
        if (results_due.size() == 0) begin
          $error("result strobe with nothing outstanding: status %0d tag %h class %0d",
                 out_status, out_tag, out_class);
          fail_count++;
        end else begin
          due = results_due.pop_front();
          if (out_status !== due.status) begin
            $error("out_status: expected %0d, got %0d", due.status, out_status);
            fail_count++;
          end
          if (out_tag !== due.tag) begin
            $error("out_tag: expected %h, got %h", due.tag, out_tag);
            fail_count++;
          end
          if (out_class !== due.cls) begin
            $error("out_class: expected %0d, got %0d", due.cls, out_class);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        fresh = serve_command(op_t'(in_op), in_item_class, in_item_tag);
        results_due.insert(results_due.size(), fresh);
        n_cmds++;
        case (fresh.status)
          ST_FULL:    n_full++;
          ST_EMPTY:   n_empty++;
          ST_REFUSED: n_refused++;
          default:    ;
        endcase
      end
    end
    outstanding <= results_due.size();
  end

endmodule

// File: test/tb_two_class_fifo_oldest_first.sv
// Testbench top: drives commands into the two-class FIFO and reports the verdict.
`timescale 1ns / 1ps

module tb_two_class_fifo_oldest_first;
  import tcf_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_op;
  logic [1:0]  in_item_class;
  logic [15:0] in_item_tag;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [15:0] out_tag;
  logic        out_class;

  int fail_count;
  int outstanding;
  int n_cmds;
  int n_full;
  int n_empty;
  int n_refused;
  int stamp_wraps;
  int cycle_count;
  int burst_left;
  bit gaps_on;

  two_class_fifo_oldest_first u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_item_class (in_item_class),
    .in_item_tag   (in_item_tag),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_tag       (out_tag),
    .out_class     (out_class)
  );

  tcf_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_item_class (in_item_class),
    .in_item_tag   (in_item_tag),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_tag       (out_tag),
    .out_class     (out_class),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .n_cmds        (n_cmds),
    .n_full        (n_full),
    .n_empty       (n_empty),
    .n_refused     (n_refused),
    .stamp_wraps   (stamp_wraps)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Hold the command until a transfer; insert a random gap between bursts
  task automatic issue(input op_t op, input logic [1:0] cls, input logic [15:0] tag);
    if (gaps_on && burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    start         <= 1'b1;
    in_op         <= op;
    in_item_class <= cls;
    in_item_tag   <= tag;
    do @(posedge clk); while (busy);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic run_directed();
    issue(OP_DEQ_OLD, CLS_DOG, 16'h0000);
    issue(OP_DEQ_DOG, CLS_CAT, 16'hFFFF);
    issue(OP_DEQ_CAT, CLS_DOG, 16'h0000);
    issue(OP_ENQ, 2'd2, 16'hFFFF);
    issue(OP_ENQ, 2'd3, 16'h0000);
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      issue(OP_ENQ, CLS_DOG, (k == 0) ? 16'h0000 :
                             (k == QUEUE_DEPTH - 1) ? 16'hFFFF : 16'(k * 16'h1111));
    end
    issue(OP_ENQ, CLS_DOG, 16'h1234);
    issue(OP_ENQ, CLS_CAT, 16'hA5A5);
    issue(OP_DEQ_OLD, CLS_DOG, 16'h0000);
    issue(OP_DEQ_CAT, CLS_DOG, 16'h0000);
    // Cat ring is empty now, so oldest-first must fall back to the dogs
    issue(OP_DEQ_OLD, CLS_CAT, 16'hFFFF);
    issue(OP_ENQ, CLS_CAT, 16'h5A5A);
    issue(OP_DEQ_OLD, CLS_DOG, 16'h0000);
    issue(OP_DEQ_DOG, CLS_DOG, 16'h0000);
  endtask

  task automatic run_mix(input int total);
    int         done;
    int         seg_left;
    int         enq_pct;
    op_t        op;
    logic [1:0] cls;
    logic [15:0] tag;
    done     = 0;
    seg_left = 0;
    enq_pct  = 50;
    while (done < total) begin
      // Pick fill-heavy, balanced or drain-heavy stretches at random so both rings hit full and empty
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0:       enq_pct = 25;
          1:       enq_pct = 50;
          default: enq_pct = 75;
        endcase
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 99) < enq_pct) begin
        op = OP_ENQ;
      end else begin
        case ($urandom_range(0, 3))
          0, 1:    op = OP_DEQ_OLD;
          2:       op = OP_DEQ_DOG;
          default: op = OP_DEQ_CAT;
        endcase
      end
      cls = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0:       tag = 16'h0000;
        1:       tag = 16'hFFFF;
        default: tag = 16'($urandom);
      endcase
      issue(op, cls, tag);
      done++;
      seg_left--;
    end
  endtask

  initial begin
    cycle_count   = 0;
    burst_left    = 0;
    gaps_on       = 1'b1;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_op         <= OP_ENQ;
    in_item_class <= CLS_DOG;
    in_item_tag   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    drain();
    run_mix(1330);
    drain();
    run_mix(200);
    drain();
    repeat (4) @(posedge clk);

    $display("Ran %0d commands in directed and random phases; %0d full, %0d empty, %0d refused",
             n_cmds, n_full, n_empty, n_refused);
    $display("Stamp counter wrapped %0d time(s), %0d field mismatches", stamp_wraps, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
